// File: hw/rtl/mesif_cache_line_controller_assert.svh
// Assertion macros shared by the checker files.
`ifndef MESIF_CACHE_LINE_CONTROLLER_ASSERT_SVH
`define MESIF_CACHE_LINE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MESIF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mesif assertion failed");

// Next-cycle implication, disabled during reset.
`define MESIF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mesif assertion failed");

`endif

// File: hw/rtl/mesif_pkg.sv
`timescale 1ns / 1ps

package mesif_pkg;

   localparam int unsigned STATE_W = 4;
   localparam int unsigned MSG_W   = 3;
   localparam int unsigned SEND_W  = 3;
   localparam int unsigned BLOCK_W = 24;

   // line states
   localparam logic [STATE_W-1:0] ST_I  = 4'd0;
   localparam logic [STATE_W-1:0] ST_S  = 4'd1;
   localparam logic [STATE_W-1:0] ST_E  = 4'd2;
   localparam logic [STATE_W-1:0] ST_M  = 4'd3;
   localparam logic [STATE_W-1:0] ST_F  = 4'd4;
   localparam logic [STATE_W-1:0] ST_IS = 4'd5;
   localparam logic [STATE_W-1:0] ST_IM = 4'd6;
   localparam logic [STATE_W-1:0] ST_SM = 4'd7;
   localparam logic [STATE_W-1:0] ST_EM = 4'd8;
   localparam logic [STATE_W-1:0] ST_FM = 4'd9;

   // request source
   localparam logic ACT_PROC = 1'b0;
   localparam logic ACT_NTWK = 1'b1;

   // incoming message codes
   localparam logic [MSG_W-1:0] MSG_LOAD  = 3'd0;
   localparam logic [MSG_W-1:0] MSG_STORE = 3'd1;
   localparam logic [MSG_W-1:0] MSG_INV   = 3'd2;
   localparam logic [MSG_W-1:0] MSG_RECI  = 3'd3;
   localparam logic [MSG_W-1:0] MSG_RECS  = 3'd4;
   localparam logic [MSG_W-1:0] MSG_DATA  = 3'd5;
   localparam logic [MSG_W-1:0] MSG_DATAE = 3'd6;
   localparam logic [MSG_W-1:0] MSG_ACK   = 3'd7;

   // outgoing message codes
   localparam logic [SEND_W-1:0] OUT_NONE   = 3'd0;
   localparam logic [SEND_W-1:0] OUT_GETS   = 3'd1;
   localparam logic [SEND_W-1:0] OUT_GETM   = 3'd2;
   localparam logic [SEND_W-1:0] OUT_GETX   = 3'd3;
   localparam logic [SEND_W-1:0] OUT_DPROC  = 3'd4;
   localparam logic [SEND_W-1:0] OUT_DDIR   = 3'd5;
   localparam logic [SEND_W-1:0] OUT_INVACK = 3'd6;

   // response tdata layout, lowest bit up
   localparam int unsigned RSP_SEND_LSB  = 0;
   localparam int unsigned RSP_BLOCK_LSB = RSP_SEND_LSB + SEND_W;
   localparam int unsigned RSP_MISS_BIT  = RSP_BLOCK_LSB + BLOCK_W;
   localparam int unsigned RSP_ERR_BIT   = RSP_MISS_BIT + 1;
   localparam int unsigned RSP_STATE_LSB = RSP_ERR_BIT + 1;
   localparam int unsigned RSP_USED_W    = RSP_STATE_LSB + STATE_W;
   localparam int unsigned RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // request tdata layout
   localparam int unsigned REQ_MSG_LSB   = 0;
   localparam int unsigned REQ_BLOCK_LSB = REQ_MSG_LSB + MSG_W;
   localparam int unsigned REQ_USED_W    = REQ_BLOCK_LSB + BLOCK_W;
   localparam int unsigned REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   typedef struct packed {
      logic [SEND_W-1:0]  send;
      logic [STATE_W-1:0] next_state;
      logic               miss;
      logic               error;
   } rule_type;

endpackage

// File: hw/rtl/mesif_rules.sv
`timescale 1ns / 1ps

module mesif_rules (
   input  logic [mesif_pkg::STATE_W-1:0] line_state,
   input  logic                          action,
   input  logic [mesif_pkg::MSG_W-1:0]   message,
   output mesif_pkg::rule_type           rule
);
   import mesif_pkg::*;

   logic is_load;
   logic is_store;

   assign is_load  = (message == MSG_LOAD);
   assign is_store = (message == MSG_STORE);

   always_comb begin
      // illegal by default: nothing sent, state held
      rule.send       = OUT_NONE;
      rule.next_state = line_state;
      rule.miss       = 1'b0;
      rule.error      = 1'b1;

      if (action == ACT_PROC) begin
         if (is_load || is_store) begin
            unique case (line_state)
               ST_I: begin
                  rule.send       = is_load ? OUT_GETS : OUT_GETM;
                  rule.next_state = is_load ? ST_IS : ST_IM;
                  rule.miss       = 1'b1;
                  rule.error      = 1'b0;
               end
               ST_S: begin
                  rule.send       = is_load ? OUT_DPROC : OUT_GETM;
                  rule.next_state = is_load ? ST_S : ST_SM;
                  rule.error      = 1'b0;
               end
               ST_E: begin
                  rule.send       = is_load ? OUT_DPROC : OUT_GETX;
                  rule.next_state = is_load ? ST_E : ST_EM;
                  rule.error      = 1'b0;
               end
               ST_M: begin
                  rule.send       = OUT_DPROC;
                  rule.next_state = ST_M;
                  rule.error      = 1'b0;
               end
               ST_F: begin
                  rule.send       = is_load ? OUT_DPROC : OUT_GETM;
                  rule.next_state = is_load ? ST_F : ST_FM;
                  rule.error      = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end else begin
         unique case (line_state)
            ST_S: begin
               if (message == MSG_INV) begin
                  rule.send       = OUT_INVACK;
                  rule.next_state = ST_I;
                  rule.error      = 1'b0;
               end
            end
            ST_M, ST_E, ST_F: begin
               if (message == MSG_RECI) begin
                  rule.send       = OUT_DDIR;
                  rule.next_state = ST_I;
                  rule.error      = 1'b0;
               end else if (message == MSG_RECS) begin
                  rule.send       = OUT_DDIR;
                  rule.next_state = (line_state == ST_M) ? ST_S : ST_F;
                  rule.error      = 1'b0;
               end
            end
            ST_IS: begin
               if (message == MSG_DATA || message == MSG_DATAE) begin
                  rule.send       = OUT_DPROC;
                  rule.next_state = (message == MSG_DATA) ? ST_S : ST_E;
                  rule.error      = 1'b0;
               end
            end
            ST_IM: begin
               if (message == MSG_DATA) begin
                  rule.send       = OUT_DPROC;
                  rule.next_state = ST_M;
                  rule.error      = 1'b0;
               end
            end
            ST_SM: begin
               if (message == MSG_INV) begin
                  rule.send       = OUT_INVACK;
                  rule.next_state = ST_IM;
                  rule.error      = 1'b0;
               end else if (message == MSG_ACK) begin
                  rule.send       = OUT_DPROC;
                  rule.next_state = ST_M;
                  rule.error      = 1'b0;
               end
            end
            ST_EM, ST_FM: begin
               if (message == MSG_RECI) begin
                  rule.send       = OUT_DDIR;
                  rule.next_state = ST_IM;
                  rule.error      = 1'b0;
               end else if (message == MSG_RECS) begin
                  rule.send       = OUT_DDIR;
                  rule.next_state = ST_FM;
                  rule.error      = 1'b0;
               end else if (message == MSG_ACK) begin
                  rule.send       = OUT_DPROC;
                  rule.next_state = ST_M;
                  rule.error      = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/mesif_cache_line_controller.sv
`timescale 1ns / 1ps

// A request is held in the input register, then its response in the response register.
// Throughput: one request per cycle while the response side is not stalled; the line
// state updates as a request leaves the input register, so the next request already sees it.
// A stalled response register backs up into the input register, then tready.
// Reset (synchronous, active high) sets the line to I and empties both stages.
module mesif_cache_line_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // message[2:0], block_id[26:3], zero fill
   input  logic [mesif_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // sent_message[2:0], out_block[26:3], miss[27], error[28],
   // line_state_out[32:29], zero fill
   output logic [mesif_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import mesif_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_action_ff;
   logic [MSG_W-1:0]      in_msg_ff;
   logic [BLOCK_W-1:0]    in_block_ff;
   logic [STATE_W-1:0]    state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  advance;
   logic                  req_take;
   logic [BLOCK_W-1:0]    out_block;
   rule_type              rule;

   mesif_rules u_rules (
      .line_state (state_ff),
      .action     (in_action_ff),
      .message    (in_msg_ff),
      .rule       (rule)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign out_block  = rule.error ? '0 : in_block_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      state_in     = state_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            state_in = rule.next_state;
         end
         in_valid_in = req_take;
      end else if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_SEND_LSB +: SEND_W]   = rule.send;
      rsp_data_in[RSP_BLOCK_LSB +: BLOCK_W] = out_block;
      rsp_data_in[RSP_MISS_BIT]             = rule.miss;
      rsp_data_in[RSP_ERR_BIT]              = rule.error;
      rsp_data_in[RSP_STATE_LSB +: STATE_W] = rule.next_state;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_I;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_tuser;
         in_msg_ff    <= req_tdata[REQ_MSG_LSB +: MSG_W];
         in_block_ff  <= req_tdata[REQ_BLOCK_LSB +: BLOCK_W];
      end
      if (advance && in_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hw/rtl/mesif_checker.sv
`timescale 1ns / 1ps
`include "mesif_cache_line_controller_assert.svh"

module mesif_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mesif_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mesif_pkg::*;

   logic [SEND_W-1:0]  rsp_send;
   logic [BLOCK_W-1:0] rsp_block;
   logic               rsp_miss;
   logic               rsp_err;
   logic [STATE_W-1:0] rsp_state;
   logic               req_fire;

   assign rsp_send  = rsp_tdata[RSP_SEND_LSB +: SEND_W];
   assign rsp_block = rsp_tdata[RSP_BLOCK_LSB +: BLOCK_W];
   assign rsp_miss  = rsp_tdata[RSP_MISS_BIT];
   assign rsp_err   = rsp_tdata[RSP_ERR_BIT];
   assign rsp_state = rsp_tdata[RSP_STATE_LSB +: STATE_W];
   assign req_fire  = req_tvalid && req_tready;

   `MESIF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // a rejected request sends nothing and carries no block
   `MESIF_ASSERT_IMP(a_err_quiet, clock, reset, rsp_tvalid && rsp_err,
      rsp_send == OUT_NONE && rsp_block == '0 && !rsp_miss)

   `MESIF_ASSERT_IMP(a_ok_sends, clock, reset, rsp_tvalid && !rsp_err,
      rsp_send != OUT_NONE)

   // a miss always launches a fetch and leaves the line waiting for data
   `MESIF_ASSERT_IMP(a_miss_fetch, clock, reset, rsp_tvalid && rsp_miss,
      (rsp_send == OUT_GETS && rsp_state == ST_IS) ||
      (rsp_send == OUT_GETM && rsp_state == ST_IM))

   // two-stage pipe: a response cannot show up unless a request was taken into the input register ahead of it
   `MESIF_ASSERT_IMP(a_no_phantom, clock, reset,
      $rose(rsp_tvalid) && !$past(reset, 2) && !$past(reset),
      $past(req_fire, 2))

endmodule

bind mesif_cache_line_controller mesif_checker u_mesif_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
